// ===== src/ncfp_pkg.sv =====
package ncfp_pkg;

	localparam int unsigned DEF_MAX_SEARCH  = 16;
	localparam int unsigned DEF_FRAC_DIGITS = 5;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned DEG_W  = 10;
	localparam int unsigned MIN_W  = 24;
	localparam int unsigned HEMI_W = 8;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic              valid;
		logic              ok;
		logic [DEG_W-1:0]  degrees;
		logic [MIN_W-1:0]  minutes;
		logic [HEMI_W-1:0] hemi;
	} result_t;

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned r;
		r = 1;
		for (int unsigned k = 0; k < n; k++) begin
			r = r * 10;
		end
		return r;
	endfunction

endpackage

// ===== src/ncfp_core.sv =====
module ncfp_core #(
	parameter int unsigned MAX_SEARCH  = ncfp_pkg::DEF_MAX_SEARCH,
	parameter int unsigned FRAC_DIGITS = ncfp_pkg::DEF_FRAC_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [ncfp_pkg::CHAR_W-1:0]   char_code,
	input  logic                          field_start,
	output ncfp_pkg::result_t             res
);

	localparam int unsigned IW = $clog2(MAX_SEARCH);
	localparam int unsigned FW = $clog2(ncfp_pkg::pow10(FRAC_DIGITS));
	localparam int unsigned CW = $clog2(FRAC_DIGITS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SEARCH - 1);
	localparam logic [ncfp_pkg::MIN_W-1:0] MIN_SCALE =
		ncfp_pkg::MIN_W'(ncfp_pkg::pow10(FRAC_DIGITS));

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SCAN = 2'd1;
	localparam logic [1:0] PH_HEMI = 2'd2;

	logic [1:0]    phase_q, phase_n, ph;
	logic [IW-1:0] idx_q, idx_n, idx;
	logic          dot_q, dot_n, dot;
	logic [2:0]    icnt_q, icnt_n, icnt;
	logic [9:0]    hi_q, hi_n, hi;
	logic [3:0]    tens_q, tens_n, tens;
	logic [3:0]    ones_q, ones_n, ones;
	logic [FW-1:0] frac_q, frac_n, frac;
	logic [CW-1:0] fcnt_q, fcnt_n, fcnt;
	logic          fstop_q, fstop_n, fstop;
	logic          fail_q, fail_n, fail;

	logic          is_digit;
	logic [3:0]    digit;
	logic          last;
	logic [FW-1:0] frac_w;
	logic [FW-1:0] frac_inc;
	logic [12:0]   hi_x10;
	logic [6:0]    lo;

	assign is_digit = (char_code >= ncfp_pkg::CH_ZERO) && (char_code <= ncfp_pkg::CH_NINE);
	assign digit    = char_code[3:0];

	always_comb begin
		if (field_start) begin
			ph    = PH_SCAN;
			idx   = '0;
			dot   = 1'b0;
			icnt  = '0;
			hi    = '0;
			tens  = '0;
			ones  = '0;
			frac  = '0;
			fcnt  = '0;
			fstop = 1'b0;
			fail  = 1'b0;
		end else begin
			ph    = phase_q;
			idx   = idx_q;
			dot   = dot_q;
			icnt  = icnt_q;
			hi    = hi_q;
			tens  = tens_q;
			ones  = ones_q;
			frac  = frac_q;
			fcnt  = fcnt_q;
			fstop = fstop_q;
			fail  = fail_q;
		end
	end

	always_comb begin
		frac_w = '0;
		for (int k = 0; k < FRAC_DIGITS; k++) begin
			if (fcnt == CW'(k)) begin
				frac_w = FW'(ncfp_pkg::pow10(FRAC_DIGITS - 1 - k));
			end
		end
	end

	assign frac_inc = FW'(digit) * frac_w;
	assign hi_x10   = {hi, 3'b000} + {2'b00, hi, 1'b0} + {9'd0, tens};
	assign lo       = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
	assign last     = (idx == LAST_IDX);

	always_comb begin
		phase_n = ph;
		idx_n   = idx;
		dot_n   = dot;
		icnt_n  = icnt;
		hi_n    = hi;
		tens_n  = tens;
		ones_n  = ones;
		frac_n  = frac;
		fcnt_n  = fcnt;
		fstop_n = fstop;
		fail_n  = fail;
		res     = '0;
		unique case (ph)
			PH_HEMI: begin
				res.valid   = 1'b1;
				res.ok      = 1'b1;
				res.degrees = hi;
				res.minutes = ncfp_pkg::MIN_W'(lo) * MIN_SCALE + ncfp_pkg::MIN_W'(frac);
				res.hemi    = char_code;
				phase_n     = PH_IDLE;
			end
			PH_SCAN: begin
				if (char_code == ncfp_pkg::CH_NUL) begin
					res.valid = 1'b1;
					phase_n   = PH_IDLE;
				end else if (char_code == ncfp_pkg::CH_COMMA) begin
					if (!dot || fail || last) begin
						res.valid = 1'b1;
						phase_n   = PH_IDLE;
					end else begin
						phase_n = PH_HEMI;
						idx_n   = idx + IW'(1);
					end
				end else begin
					if (!dot) begin
						if (char_code == ncfp_pkg::CH_DOT) begin
							dot_n = 1'b1;
							if (idx < 2 || idx > 5) begin
								fail_n = 1'b1;
							end
						end else if (!is_digit) begin
							fail_n = 1'b1;
						end else if (icnt < 3'd5) begin
							hi_n   = hi_x10[9:0];
							tens_n = ones;
							ones_n = digit;
							icnt_n = icnt + 3'd1;
						end else begin
							fail_n = 1'b1;
						end
					end else if (!fstop) begin
						if (!is_digit) begin
							fstop_n = 1'b1;
						end else if (fcnt < CW'(FRAC_DIGITS)) begin
							frac_n = frac + frac_inc;
							fcnt_n = fcnt + CW'(1);
						end
					end
					if (last) begin
						res.valid = 1'b1;
						phase_n   = PH_IDLE;
					end else begin
						idx_n = idx + IW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			dot_q   <= 1'b0;
			icnt_q  <= '0;
			hi_q    <= '0;
			tens_q  <= '0;
			ones_q  <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			fstop_q <= 1'b0;
			fail_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			dot_q   <= dot_n;
			icnt_q  <= icnt_n;
			hi_q    <= hi_n;
			tens_q  <= tens_n;
			ones_q  <= ones_n;
			frac_q  <= frac_n;
			fcnt_q  <= fcnt_n;
			fstop_q <= fstop_n;
			fail_q  <= fail_n;
		end
	end

endmodule

// ===== src/nmea_coordinate_field_parser_top.sv =====
// A beat accepted into the input register loads its result (if any) into the output
// register when the core advances on it; the result beat is offered from there.
// Throughput: one input beat per cycle; a beat that ends a field waits in the
// input register only while an earlier result is still held by m_axis_tready.
// Reset: arst_n clears the parse state to idle and empties both stages;
// no field is in progress after reset.
module nmea_coordinate_field_parser_top #(
	parameter int unsigned MAX_SEARCH  = ncfp_pkg::DEF_MAX_SEARCH,
	parameter int unsigned FRAC_DIGITS = ncfp_pkg::DEF_FRAC_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tuser,  // [0] field_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [9:0] degrees, [33:10] minutes_scaled,
	                                   // [41:34] hemisphere, [47:42] zero
	output logic        m_axis_tuser   // [0] parse_ok
);

	logic                                 valid_s1;
	logic [ncfp_pkg::CHAR_W-1:0]          char_s1;
	logic                                 start_s1;
	logic                                 advance;
	ncfp_pkg::result_t                    res;

	logic                                 out_valid_q;
	logic                                 ok_q;
	logic [ncfp_pkg::DEG_W-1:0]           deg_q;
	logic [ncfp_pkg::MIN_W-1:0]           min_q;
	logic [ncfp_pkg::HEMI_W-1:0]          hemi_q;

	assign advance       = valid_s1 && (!res.valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	ncfp_core #(
		.MAX_SEARCH  (MAX_SEARCH),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.char_code   (char_s1),
		.field_start (start_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			ok_q   <= res.ok;
			deg_q  <= res.degrees;
			min_q  <= res.minutes;
			hemi_q <= res.hemi;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = ok_q;
	assign m_axis_tdata  = {6'b000000, hemi_q, min_q, deg_q};

endmodule

// ===== src/ncfp_checker.sv =====
module ncfp_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// input only stalls behind a held result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output register");

	// rejected field carries zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("rejected field with nonzero payload");

	// parsed values stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[9:0] <= 10'd999 && m_axis_tdata[33:10] <= 24'd9999999)
		else $error("parsed value out of range");

	// pad bits are zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0)
		else $error("pad bits set in result beat");

endmodule

bind nmea_coordinate_field_parser_top ncfp_props u_ncfp_props (.*);
